// ===== src/afd_pkg.sv =====
// Package for the frame deframer: phase type, result kinds, delimiter and checksum constants.
// No dependencies. Imported by api_frame_deframer_unit.
package afd_pkg;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN_HI  = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_TYPE    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK   = 3'd5
	} phase_t;

	localparam logic [2:0] K_TYPE = 3'd0;
	localparam logic [2:0] K_DATA = 3'd1;
	localparam logic [2:0] K_GOOD = 3'd2;
	localparam logic [2:0] K_BAD  = 3'd3;
	localparam logic [2:0] K_DROP = 3'd4;

	localparam logic [7:0]  DELIM_BYTE = 8'h7E;
	localparam logic [7:0]  SUM_GOOD   = 8'hFF;
	localparam logic [15:0] LEN_HI_MASK = 16'hFF00;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [15:0] byte_index;
		logic [15:0] payload_length;
	} result_t;

endpackage

// ===== src/api_frame_deframer_unit.sv =====
// Delimited length/checksum frame deframer: phase machine plus two-entry result queue.
// Latency: with the result queue empty, a result is offered on out_valid the cycle after
// its byte is accepted; otherwise it waits behind the results already queued.
// Throughput: one byte per cycle unless both queue entries are full (in_ready low); the
// two-entry result queue keeps input flowing while one result waits.
// Reset (arst_n low, asynchronous): hunting for delimiter, counters cleared, queue empty.
// Depends on afd_pkg.
module api_frame_deframer_unit
	import afd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  value,
	output logic [15:0] byte_index,
	output logic [15:0] payload_length
);

	phase_t      phase_q, phase_d;
	logic [15:0] length_q, length_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] count_q, count_d;

	logic        has_result;
	result_t     res;
	logic [15:0] full_len;
	logic [15:0] count_inc;
	logic [7:0]  sum_add;

	logic        accept, push, pop;
	logic [1:0]  fill_q;
	result_t     head_q, tail_q;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (fill_q != 2'd2);
	assign full_len  = length_q | {8'd0, rx_byte};
	assign count_inc = count_q + 16'd1;
	assign sum_add   = sum_q + rx_byte;

	// next state
	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		sum_d    = sum_q;
		count_d  = count_q;
		case (phase_q)
			PH_LEN_HI: begin
				length_d = {rx_byte, 8'd0} & LEN_HI_MASK;
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (full_len == 16'd0) begin
					length_d = 16'd0;
					phase_d  = PH_HUNT;
				end else begin
					length_d = full_len - 16'd1;
					phase_d  = PH_TYPE;
				end
			end
			PH_TYPE: begin
				sum_d   = rx_byte;
				count_d = 16'd0;
				phase_d = (length_q == 16'd0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_d   = sum_add;
				count_d = count_inc;
				if (count_inc >= length_q) phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				sum_d   = sum_add;
				phase_d = PH_HUNT;
			end
			default: begin
				// unused codes behave as hunting
				if (rx_byte == DELIM_BYTE) begin
					phase_d = PH_LEN_HI;
					sum_d   = 8'd0;
					count_d = 16'd0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	// result for the current byte
	always_comb begin
		has_result = 1'b0;
		res        = '0;
		case (phase_q)
			PH_LEN_LO: begin
				if (full_len == 16'd0) begin
					has_result = 1'b1;
					res.kind   = K_DROP;
				end
			end
			PH_TYPE: begin
				has_result         = 1'b1;
				res.kind           = K_TYPE;
				res.value          = rx_byte;
				res.payload_length = length_q;
			end
			PH_PAYLOAD: begin
				has_result         = 1'b1;
				res.kind           = K_DATA;
				res.value          = rx_byte;
				res.byte_index     = count_q;
				res.payload_length = length_q;
			end
			PH_CHECK: begin
				has_result         = 1'b1;
				res.kind           = (sum_add == SUM_GOOD) ? K_GOOD : K_BAD;
				res.payload_length = length_q;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			length_q <= 16'd0;
			sum_q    <= 8'd0;
			count_q  <= 16'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			sum_q    <= sum_d;
			count_q  <= count_d;
		end
	end

	assign push = accept && has_result;
	assign pop  = out_valid && out_ready;

	// two-entry result queue, head drives the outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			case (fill_q)
				2'd0: if (push) fill_q <= 2'd1;
				2'd1: begin
					if (push && !pop) fill_q <= 2'd2;
					else if (pop && !push) fill_q <= 2'd0;
				end
				2'd2: if (pop) fill_q <= 2'd1;
				default: fill_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (fill_q)
			2'd0: if (push) head_q <= res;
			2'd1: begin
				if (push && pop) head_q <= res;
				else if (push) tail_q <= res;
			end
			2'd2: if (pop) head_q <= tail_q;
			default: head_q <= res;
		endcase
	end

	assign out_valid      = (fill_q != 2'd0);
	assign kind           = head_q.kind;
	assign value          = head_q.value;
	assign byte_index     = head_q.byte_index;
	assign payload_length = head_q.payload_length;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("result queue fill out of range");

	a_type_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_TYPE) |=> out_valid)
		else $error("type byte produced no result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (count_q < length_q))
		else $error("payload count passed frame length");

	a_out_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == K_TYPE || kind == K_DATA || kind == K_GOOD ||
			kind == K_BAD || kind == K_DROP))
		else $error("invalid result kind offered");

endmodule
